@@ rtl/cv3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_pkg
// Types, constants and codes shared by the 3x3 RGB convolution blocks.
// ----------------------------------------------------------------------------
package cv3_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int FILL_MAX   = 2 * MAX_WIDTH + 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(FILL_MAX + 1);

    localparam int WIDTH_W = 13;
    localparam int KROW_W  = 24;
    localparam int DIV_W   = 8;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int CFG_A_W = 3;
    localparam int PROD_W  = 17;
    localparam int ACC_W   = 20;
    localparam int REM_W   = ACC_W - 1;
    localparam int TAPS    = 9;
    localparam int STEP_W  = 4;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_LINE_WIDTH   = 3'd0,
        CFG_KROW_ABOVE   = 3'd1,
        CFG_KROW_CENTER  = 3'd2,
        CFG_KROW_BELOW   = 3'd3,
        CFG_DIVISOR      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_DINIT,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [WIDTH_W-1:0] line_width;
        logic [KROW_W-1:0]  krow_above;
        logic [KROW_W-1:0]  krow_center;
        logic [KROW_W-1:0]  krow_below;
        logic [DIV_W-1:0]   divisor;
    } t_cfg;

    typedef struct packed {
        logic              take;
        logic              tap_issue;
        logic              div_init;
        logic              div_step;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/cv3_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cv3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8195
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/cv3_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_dp
// Datapath: pixel delay line, tap addressing, multiply-accumulate lanes,
// bit-serial dividers with clamping and the output register.
// ----------------------------------------------------------------------------
module cv3_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cv3_pkg::t_cfg         i_cfg,
    input  wire cv3_pkg::t_cmd         i_cmd,
    output cv3_pkg::t_stat             o_stat,
    input  wire logic [23:0]           i_pix,
    input  wire logic                  i_first,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [23:0]                o_out_data,
    output logic                       o_out_last
);

    import cv3_pkg::*;

    logic [ADDR_W-1:0]     r_wr_ptr;
    logic [ADDR_W-1:0]     r_base;
    logic [CNT_W-1:0]      r_fill;
    logic                  r_last;
    logic                  r_rd_v;
    logic signed [CH_W-1:0] r_rd_coef;
    logic                  r_prod_v;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  r_acc [3];
    logic [REM_W-1:0]      r_rem [3];
    logic [CH_W-1:0]       r_q [3];
    logic                  r_neg [3];
    logic                  r_sat [3];
    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_data;
    logic                  r_out_last;

    logic [WIDTH_W-1:0]    w_eff;
    logic [CNT_W-1:0]      w_ext;
    logic [CNT_W-1:0]      cnt_now;
    logic [CNT_W-1:0]      age;
    logic [ADDR_W:0]       diff;
    logic [ADDR_W-1:0]     rd_addr;
    logic [PIX_W-1:0]      rd_data;
    logic [DIV_W-1:0]      dvs;
    logic [2:0]            shamt;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      sat_lim;
    logic [CH_W-1:0]       res [3];

    function automatic logic [CNT_W-1:0] tap_age(input logic [STEP_W-1:0] k,
                                                 input logic [CNT_W-1:0] w);
        logic [CNT_W-1:0] w2;
        w2 = w << 1;
        unique case (k)
            4'd0:    tap_age = w2 + CNT_W'(2);
            4'd1:    tap_age = w2 + CNT_W'(1);
            4'd2:    tap_age = w2;
            4'd3:    tap_age = w + CNT_W'(2);
            4'd4:    tap_age = w + CNT_W'(1);
            4'd5:    tap_age = w;
            4'd6:    tap_age = CNT_W'(2);
            4'd7:    tap_age = CNT_W'(1);
            default: tap_age = '0;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] tap_coef(input logic [STEP_W-1:0] k,
                                                 input t_cfg c);
        unique case (k)
            4'd0:    tap_coef = c.krow_above[7:0];
            4'd1:    tap_coef = c.krow_above[15:8];
            4'd2:    tap_coef = c.krow_above[23:16];
            4'd3:    tap_coef = c.krow_center[7:0];
            4'd4:    tap_coef = c.krow_center[15:8];
            4'd5:    tap_coef = c.krow_center[23:16];
            4'd6:    tap_coef = c.krow_below[7:0];
            4'd7:    tap_coef = c.krow_below[15:8];
            default: tap_coef = c.krow_below[23:16];
        endcase
    endfunction

    always_comb begin
        if (i_cfg.line_width < WIDTH_W'(3)) begin
            w_eff = WIDTH_W'(3);
        end else if (i_cfg.line_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = i_cfg.line_width;
        end
        w_ext   = CNT_W'(w_eff);
        cnt_now = i_first ? '0 : r_fill;
        age     = tap_age(i_cmd.step, w_ext);
        diff    = {1'b0, r_base} - (ADDR_W + 1)'(age);
        if (diff[ADDR_W]) begin
            rd_addr = ADDR_W'(diff + (ADDR_W + 1)'(LINE_DEPTH));
        end else begin
            rd_addr = diff[ADDR_W-1:0];
        end
        dvs     = (i_cfg.divisor == '0) ? DIV_W'(1) : i_cfg.divisor;
        shamt   = 3'd7 - i_cmd.step[2:0];
        trial   = REM_W'(dvs) << shamt;
        sat_lim = REM_W'({dvs, 8'd0});
        for (int c = 0; c < 3; c++) begin
            if (r_neg[c]) begin
                res[c] = '0;
            end else if (r_sat[c]) begin
                res[c] = 8'd255;
            end else begin
                res[c] = r_q[c];
            end
        end
    end

    assign o_stat.emit     = (cnt_now >= ((w_ext << 1) + CNT_W'(2)));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    cv3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_pix),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_wr_ptr <= (r_wr_ptr == ADDR_W'(LINE_DEPTH - 1)) ? '0
                                                                : r_wr_ptr + ADDR_W'(1);
                r_fill   <= (cnt_now < CNT_W'(FILL_MAX)) ? cnt_now + CNT_W'(1) : cnt_now;
            end
            r_rd_v   <= i_cmd.tap_issue;
            r_prod_v <= r_rd_v;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_base <= r_wr_ptr;
            r_last <= i_last;
        end
        if (i_cmd.tap_issue) begin
            r_rd_coef <= signed'(tap_coef(i_cmd.step, i_cfg));
        end
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= signed'(PROD_W'(rd_data[CH_W*c +: CH_W]))
                         * PROD_W'(r_rd_coef);
            if (i_cmd.take) begin
                r_acc[c] <= '0;
            end else if (r_prod_v) begin
                r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
            end
            if (i_cmd.div_init) begin
                r_neg[c] <= r_acc[c][ACC_W-1];
                r_rem[c] <= r_acc[c][REM_W-1:0];
                r_sat[c] <= (r_acc[c][REM_W-1:0] >= sat_lim);
                r_q[c]   <= '0;
            end else if (i_cmd.div_step) begin
                if (r_rem[c] >= trial) begin
                    r_rem[c] <= r_rem[c] - trial;
                    r_q[c]   <= {r_q[c][CH_W-2:0], 1'b1};
                end else begin
                    r_q[c]   <= {r_q[c][CH_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= {res[2], res[1], res[0]};
            r_out_last <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/cv3_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_ctrl
// Sequencer: accepts a pixel, walks the nine taps, drains the multiply
// pipeline, runs the divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module cv3_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire cv3_pkg::t_stat i_stat,
    output cv3_pkg::t_cmd       o_cmd
);

    import cv3_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.step = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_cnt      = '0;
                    if (i_stat.emit) begin
                        n_state = S_TAP;
                    end
                end
            end
            S_TAP: begin
                o_cmd.tap_issue = 1'b1;
                if (r_cnt == STEP_W'(TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_cnt == STEP_W'(1)) begin
                    n_cnt   = '0;
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == STEP_W'(CH_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_drain_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DINIT) |-> $past(r_state == S_TAP, 3))
        else $error("divider started without a two-cycle drain");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && !i_stat.emit) |=> (r_state == S_IDLE))
        else $error("pixel without result left the idle state");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_cnt < STEP_W'(TAPS)))
        else $error("tap counter ran past the last tap");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("output register overwritten before transfer");
`endif

endmodule

`default_nettype wire

@@ rtl/conv3x3_rgb_clamp_top.sv @@
`default_nettype none
// Input: a pixel that yields no result leaves the input ready; one that yields a result holds
// the input off until its result is loaded into the output register. Its nine taps are read
// one per cycle through the single read port of the line RAM, then the multiply pipeline
// drains and the 8-step divider runs; a stalled output adds its wait.
// Reset (synchronous, active low) restores the register defaults and clears the fill count,
// the write pointer and all handshake state; the line RAM keeps its contents.
// ----------------------------------------------------------------------------
// conv3x3_rgb_clamp_top
// 3x3 RGB convolution with integer divide and clamp to 0..255, over a pixel
// stream in raster order, with a plain register write port.
// ----------------------------------------------------------------------------
module conv3x3_rgb_clamp_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [23:0] i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // red_in, green_in, blue_in
    input  wire logic        i_s_axis_tuser,   // first_pixel
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // red_out, green_out, blue_out
    output logic             o_m_axis_tlast
);

    import cv3_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width  <= WIDTH_W'(640);
            r_cfg.krow_above  <= '0;
            r_cfg.krow_center <= KROW_W'(24'h000100);
            r_cfg.krow_below  <= '0;
            r_cfg.divisor     <= DIV_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LINE_WIDTH:  r_cfg.line_width  <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_KROW_ABOVE:  r_cfg.krow_above  <= i_cfg_wdata;
                CFG_KROW_CENTER: r_cfg.krow_center <= i_cfg_wdata;
                CFG_KROW_BELOW:  r_cfg.krow_below  <= i_cfg_wdata;
                CFG_DIVISOR:     r_cfg.divisor     <= i_cfg_wdata[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cv3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cv3_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_pix       (i_s_axis_tdata),
        .i_first     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
